// ===== rtl/rld_pkg.sv =====
package rld_pkg;

  localparam int unsigned ITER_LIMIT_DEF = 15;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned COEF_W         = 48;
  localparam int unsigned TOL_W          = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_K0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1678;

  localparam logic signed [64:0] FMAX65   = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]        FMAX     = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] ONE_Q44  = 65'sh0_0000_1000_0000_0000;
  localparam logic [63:0]        R2_EPS   = 64'd281474976;
  localparam logic signed [63:0] R_LIMIT  = 64'sh0000_0000_FFFF_FFFF;
  localparam logic [31:0]        QCAP     = 32'h8000_0000;
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic        neg;
    logic        sh48;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] q;
    logic [63:0]        prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] v;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    return m;
  endfunction

  function automatic logic signed [63:0] clampf(input logic signed [64:0] v);
    logic signed [64:0] nfmax;
    logic signed [64:0] c;
    nfmax = -FMAX65;
    if (v > FMAX65) c = FMAX65;
    else if (v < nfmax) c = nfmax;
    else c = v;
    return c[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] s;
    if (v > 65'sd2147483647) s = S32_MAX;
    else if (v < -65'sd2147483648) s = S32_MIN;
    else s = v[31:0];
    return s;
  endfunction

endpackage

// ===== rtl/rld_mul.sv =====
module rld_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rld_pkg::mul_req_t req,
  output rld_pkg::mul_rsp_t rsp
);

  logic [63:0]  a_r, b_r;
  logic         neg_r, sh48_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r, fin_r, done_r;
  logic signed [63:0] q_r;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [6:0]   sh_amt;
  logic [127:0] pp_ext;
  logic [127:0] shv;
  logic [63:0]  m;

  always_comb begin
    ah     = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    bh     = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = ah * bh;
    sh_amt = ({6'd0, cnt_r[1]} + {6'd0, cnt_r[0]}) << 5;
    pp_ext = {64'd0, pp} << sh_amt;
    shv    = sh48_r ? (acc_r >> 48) : (acc_r >> 44);
    m      = (|shv[127:62]) ? rld_pkg::FMAX : {2'b00, shv[61:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        neg_r  <= req.neg;
        sh48_r <= req.sh48;
        acc_r  <= '0;
        cnt_r  <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_ext;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        // truncate magnitude, saturate, then apply sign
        q_r    <= neg_r ? $signed(64'd0 - m) : $signed(m);
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
  assign rsp.prod = acc_r[63:0];

endmodule

// ===== rtl/rld_div.sv =====
module rld_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rld_pkg::div_req_t req,
  output rld_pkg::div_rsp_t rsp
);

  localparam int unsigned NUM_W = 76;

  logic [NUM_W-1:0] num_r;
  logic [63:0]      den_r, rem_r;
  logic [31:0]      q_r;
  logic             ovf_r, busy_r, done_r;
  logic [6:0]       cnt_r;

  logic [64:0] rem_sh;
  logic        ge;
  logic [64:0] rem_new;
  logic [32:0] q_sh;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_new = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
    q_sh    = {q_r, ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= {req.num, 44'd0};
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= 7'(NUM_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= rem_new[63:0];
        q_r   <= q_sh[31:0];
        // once past the cap the quotient only grows: hold the flag
        if (q_sh > {1'b0, rld_pkg::QCAP}) ovf_r <= 1'b1;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = ovf_r ? rld_pkg::QCAP : q_r;

endmodule

// ===== rtl/rld_sqrt.sv =====
module rld_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  rld_pkg::sqrt_req_t req,
  output rld_pkg::sqrt_rsp_t rsp
);

  logic [63:0] v_r, res_r, sbit_r;
  logic        busy_r, done_r;
  logic [63:0] rb;

  assign rb = res_r + sbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        v_r    <= req.v;
        res_r  <= '0;
        sbit_r <= 64'd1 << 62;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= rb) begin
          v_r   <= v_r - rb;
          res_r <= (res_r >> 1) + sbit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        if (sbit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule

// ===== rtl/radial_lens_distortion_map.sv =====
// Radial lens distortion map: one request (direction, x, y in signed Q7.24 mm) in, one
// corrected point out. All products run through one shared 32x32 multiplier that takes
// four passes per 64-bit product; the square root is a 32-step unit and each quotient a
// 76-step bit-serial divider. A disabled map or a point near the centre returns the
// input point unchanged. Distort forms a first estimate, then runs fixed-point updates
// (at most ITERATION_LIMIT, 15 by default), gives up after the last update if it has
// not converged, then does two divisions and loads the output register. The block takes
// no new request until the current one finishes; a finished result waits in the output
// register.
module radial_lens_distortion_map #(
  parameter int unsigned ITERATION_LIMIT = rld_pkg::ITER_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic signed [31:0]             in_x_in,
  input  logic signed [31:0]             in_y_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_x_out,
  output logic signed [31:0]             out_y_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rld_pkg::COEF_W-1:0]     cfg_data
);

  localparam int unsigned IT_W = $clog2(ITERATION_LIMIT + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQXW, S_SQY, S_SQYW, S_BRANCH,
    S_P1, S_P1W, S_P2, S_P2W,
    S_UX, S_UXW, S_UY, S_UYW,
    S_SQRT, S_SQRTW, S_SEED, S_SEEDW,
    S_CHK, S_RSQ, S_RSQW, S_UPD, S_UPDW,
    S_DX, S_DXW, S_DY, S_DYW, S_DONE
  } state_t;

  state_t state_r, ret_r;

  logic signed [47:0] k0_r, k1_r, k2_r;
  logic               en_r;
  logic [30:0]        tol_r;

  logic               typ_r;
  logic signed [31:0] x_r, y_r, xo_r, yo_r;
  logic [31:0]        xm_r, ym_r, rp_r;
  logic [63:0]        sq_r, r2_r, s2_r, rm_r;
  logic signed [63:0] f_r, inner_r, r_r, rprev_r;
  logic [IT_W-1:0]    it_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;

  rld_pkg::mul_req_t  mul_req;
  rld_pkg::mul_rsp_t  mul_rsp;
  rld_pkg::div_req_t  div_req;
  rld_pkg::div_rsp_t  div_rsp;
  rld_pkg::sqrt_req_t sqrt_req;
  rld_pkg::sqrt_rsp_t sqrt_rsp;

  rld_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  rld_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  rld_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .rsp(sqrt_rsp));

  logic signed [63:0] k2_ext;
  logic signed [64:0] q65, rnew, dval;
  logic signed [65:0] diff;
  logic [65:0]        diff_mag;
  logic [63:0]        dmag;
  logic               d_zero, xneg_q, yneg_q;
  logic signed [64:0] xq, yq;

  always_comb begin
    k2_ext   = {{16{k2_r[47]}}, k2_r};
    q65      = {mul_rsp.q[63], mul_rsp.q};
    rnew     = $signed({33'd0, rp_r}) + q65;
    diff     = {rnew[64], rnew} - {{2{rprev_r[63]}}, rprev_r};
    diff_mag = diff[65] ? (66'd0 - diff) : diff;
    dval     = rld_pkg::ONE_Q44 - {f_r[63], f_r};
    dmag     = dval[64] ? 64'(65'd0 - dval) : dval[63:0];
    d_zero   = (dval == 65'sd0);
    xneg_q   = x_r[31] ^ dval[64];
    yneg_q   = y_r[31] ^ dval[64];
    xq       = xneg_q ? -$signed({33'd0, div_rsp.q}) : $signed({33'd0, div_rsp.q});
    yq       = yneg_q ? -$signed({33'd0, div_rsp.q}) : $signed({33'd0, div_rsp.q});
  end

  // operand select for the shared units
  always_comb begin
    mul_req  = '0;
    div_req  = '0;
    sqrt_req = '0;
    unique case (state_r)
      S_SQX: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, xm_r};
        mul_req.b     = {32'd0, xm_r};
      end
      S_SQY: begin
        mul_req.start = 1'b1;
        mul_req.a     = {32'd0, ym_r};
        mul_req.b     = {32'd0, ym_r};
      end
      S_P1: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(k2_ext);
        mul_req.b     = s2_r;
        mul_req.neg   = k2_r[47];
        mul_req.sh48  = 1'b1;
      end
      S_P2: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(inner_r);
        mul_req.b     = s2_r;
        mul_req.neg   = inner_r[63];
        mul_req.sh48  = 1'b1;
      end
      S_UX: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(f_r);
        mul_req.b     = {32'd0, xm_r};
        mul_req.neg   = f_r[63] ^ x_r[31];
      end
      S_UY: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(f_r);
        mul_req.b     = {32'd0, ym_r};
        mul_req.neg   = f_r[63] ^ y_r[31];
      end
      S_SEED: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(f_r);
        mul_req.b     = {32'd0, rp_r};
        mul_req.neg   = f_r[63];
      end
      S_RSQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = rm_r;
        mul_req.b     = rm_r;
      end
      S_UPD: begin
        mul_req.start = 1'b1;
        mul_req.a     = rld_pkg::mag64(f_r);
        mul_req.b     = rm_r;
        mul_req.neg   = f_r[63] ^ rprev_r[63];
      end
      S_SQRT: begin
        sqrt_req.start = 1'b1;
        sqrt_req.v     = r2_r;
      end
      S_DX: begin
        div_req.start = (x_r != 32'sd0) && !d_zero;
        div_req.num   = xm_r;
        div_req.den   = dmag;
      end
      S_DY: begin
        div_req.start = (y_r != 32'sd0) && !d_zero;
        div_req.num   = ym_r;
        div_req.den   = dmag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      k0_r        <= '0;
      k1_r        <= '0;
      k2_r        <= '0;
      en_r        <= 1'b0;
      tol_r       <= rld_pkg::TOL_RESET;
      it_r        <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          rld_pkg::CFG_K0:  k0_r  <= cfg_data;
          rld_pkg::CFG_K1:  k1_r  <= cfg_data;
          rld_pkg::CFG_K2:  k2_r  <= cfg_data;
          rld_pkg::CFG_EN:  en_r  <= cfg_data[0];
          rld_pkg::CFG_TOL: tol_r <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            typ_r   <= in_req_type;
            x_r     <= in_x_in;
            y_r     <= in_y_in;
            xm_r    <= in_x_in[31] ? (32'd0 - in_x_in) : in_x_in;
            ym_r    <= in_y_in[31] ? (32'd0 - in_y_in) : in_y_in;
            state_r <= S_SQX;
          end
        end
        S_SQX:  state_r <= S_SQXW;
        S_SQXW: begin
          if (mul_rsp.done) begin
            sq_r    <= mul_rsp.prod;
            state_r <= S_SQY;
          end
        end
        S_SQY:  state_r <= S_SQYW;
        S_SQYW: begin
          if (mul_rsp.done) begin
            r2_r    <= sq_r + mul_rsp.prod;
            state_r <= S_BRANCH;
          end
        end
        S_BRANCH: begin
          if (!en_r || r2_r <= rld_pkg::R2_EPS) begin
            xo_r    <= x_r;
            yo_r    <= y_r;
            state_r <= S_DONE;
          end else if (!typ_r) begin
            s2_r    <= r2_r;
            ret_r   <= S_UX;
            state_r <= S_P1;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_P1:  state_r <= S_P1W;
        S_P1W: begin
          if (mul_rsp.done) begin
            inner_r <= rld_pkg::clampf($signed({{17{k1_r[47]}}, k1_r}) + q65);
            state_r <= S_P2;
          end
        end
        S_P2:  state_r <= S_P2W;
        S_P2W: begin
          if (mul_rsp.done) begin
            f_r     <= rld_pkg::clampf($signed({{17{k0_r[47]}}, k0_r}) + q65);
            state_r <= ret_r;
          end
        end
        S_UX:  state_r <= S_UXW;
        S_UXW: begin
          if (mul_rsp.done) begin
            xo_r    <= rld_pkg::sat32($signed({{33{x_r[31]}}, x_r}) - q65);
            state_r <= S_UY;
          end
        end
        S_UY:  state_r <= S_UYW;
        S_UYW: begin
          if (mul_rsp.done) begin
            yo_r    <= rld_pkg::sat32($signed({{33{y_r[31]}}, y_r}) - q65);
            state_r <= S_DONE;
          end
        end
        S_SQRT:  state_r <= S_SQRTW;
        S_SQRTW: begin
          if (sqrt_rsp.done) begin
            rp_r    <= sqrt_rsp.root;
            s2_r    <= r2_r;
            ret_r   <= S_SEED;
            state_r <= S_P1;
          end
        end
        S_SEED:  state_r <= S_SEEDW;
        S_SEEDW: begin
          if (mul_rsp.done) begin
            r_r     <= rnew[63:0];
            it_r    <= '0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          // give up: identity mapping through the divide with f = 0
          if (it_r >= IT_W'(ITERATION_LIMIT) || r_r > rld_pkg::R_LIMIT ||
              r_r < -rld_pkg::R_LIMIT) begin
            f_r     <= '0;
            state_r <= S_DX;
          end else begin
            rprev_r <= r_r;
            rm_r    <= rld_pkg::mag64(r_r);
            state_r <= S_RSQ;
          end
        end
        S_RSQ:  state_r <= S_RSQW;
        S_RSQW: begin
          if (mul_rsp.done) begin
            s2_r    <= mul_rsp.prod;
            ret_r   <= S_UPD;
            state_r <= S_P1;
          end
        end
        S_UPD:  state_r <= S_UPDW;
        S_UPDW: begin
          if (mul_rsp.done) begin
            r_r  <= rnew[63:0];
            it_r <= it_r + IT_W'(1);
            if (diff_mag <= {35'd0, tol_r}) state_r <= S_DX;
            else state_r <= S_CHK;
          end
        end
        S_DX: begin
          if (x_r == 32'sd0) begin
            xo_r    <= '0;
            state_r <= S_DY;
          end else if (d_zero) begin
            xo_r    <= x_r[31] ? rld_pkg::S32_MIN : rld_pkg::S32_MAX;
            state_r <= S_DY;
          end else begin
            state_r <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_rsp.done) begin
            xo_r    <= rld_pkg::sat32(xq);
            state_r <= S_DY;
          end
        end
        S_DY: begin
          if (y_r == 32'sd0) begin
            yo_r    <= '0;
            state_r <= S_DONE;
          end else if (d_zero) begin
            yo_r    <= y_r[31] ? rld_pkg::S32_MIN : rld_pkg::S32_MAX;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_rsp.done) begin
            yo_r    <= rld_pkg::sat32(yq);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_x_r     <= xo_r;
            out_y_r     <= yo_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted but block still ready");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r <= IT_W'(ITERATION_LIMIT))
    else $error("update count beyond limit");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_SQXW || state_r == S_SQYW || state_r == S_P1W ||
                      state_r == S_P2W || state_r == S_UXW || state_r == S_UYW ||
                      state_r == S_SEEDW || state_r == S_RSQW || state_r == S_UPDW))
    else $error("product returned outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DXW || state_r == S_DYW))
    else $error("quotient returned outside a wait state");

endmodule

// ===== verif/rld_checker.sv =====
`timescale 1ns / 100ps

module rld_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [31:0]            in_x_in,
  input  logic signed [31:0]            in_y_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            out_x_out,
  input  logic signed [31:0]            out_y_out,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rld_pkg::COEF_W-1:0]    cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int ITER_MAX = rld_pkg::ITER_LIMIT_DEF;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  point_t expected_points[$];
  int nerr = 0;

  logic signed [63:0] k0 = '0, k1 = '0, k2 = '0;
  logic               coef_en = 1'b0;
  logic [63:0]        tol = 64'(rld_pkg::TOL_RESET);

  assign errors = nerr;

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] limit_fraction(input logic signed [64:0] v);
    logic signed [64:0] hi;
    hi = $signed({1'b0, rld_pkg::FMAX});
    if (v > hi) return rld_pkg::FMAX;
    if (v < -hi) return -$signed(rld_pkg::FMAX);
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] limit_s32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -65'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // signed (a*b) >> s, magnitude truncated, capped at FMAX
  function automatic logic signed [63:0] scaled_product(input logic [63:0] am, input bit an,
                                                         input logic [63:0] bm, input bit bn,
                                                         input int s);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, am} * {64'd0, bm};
    p = p >> s;
    m = (p > {64'd0, rld_pkg::FMAX}) ? rld_pkg::FMAX : p[63:0];
    return (an != bn) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] radial_fraction(input logic [63:0] s2);
    logic signed [63:0] t, inner;
    logic signed [64:0] acc;
    t = scaled_product(magnitude(k2), k2[63], s2, 1'b0, 48);
    acc = k1;
    acc = acc + t;
    inner = limit_fraction(acc);
    t = scaled_product(magnitude(inner), inner[63], s2, 1'b0, 48);
    acc = k0;
    acc = acc + t;
    return limit_fraction(acc);
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scale_by_divisor(input logic signed [63:0] p,
                                                           input logic signed [63:0] d);
    logic [127:0] q;
    logic signed [64:0] sq;
    if (p == 0) return 32'sd0;
    if (d == 0) return p[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    q = ({64'd0, magnitude(p)} << 44) / {64'd0, magnitude(d)};
    if (q > 128'(rld_pkg::QCAP)) q = 128'(rld_pkg::QCAP);
    sq = $signed({1'b0, q[63:0]});
    if (p[63] != d[63]) sq = -sq;
    return limit_s32(sq);
  endfunction

  function automatic point_t map_point(input logic rt, input logic signed [31:0] xi,
                                       input logic signed [31:0] yi);
    point_t o;
    logic signed [63:0] x, y, f, rp, r, rprev, one;
    logic [63:0] xm, ym, r2, rm;
    logic signed [64:0] w;
    int it;
    x = xi;
    y = yi;
    xm = magnitude(x);
    ym = magnitude(y);
    r2 = xm * xm + ym * ym;
    o.x = xi;
    o.y = yi;
    if (coef_en && r2 > rld_pkg::R2_EPS) begin
      f = radial_fraction(r2);
      if (!rt) begin
        w = x;
        w = w - scaled_product(magnitude(f), f[63], xm, x[63], 44);
        o.x = limit_s32(w);
        w = y;
        w = w - scaled_product(magnitude(f), f[63], ym, y[63], 44);
        o.y = limit_s32(w);
      end else begin
        rp = floor_root(r2);
        r = rp + scaled_product(magnitude(f), f[63], rp, 1'b0, 44);
        it = 0;
        forever begin
          rm = magnitude(r);
          // give up: iteration limit or radius out of range
          if (it >= ITER_MAX || r > rld_pkg::R_LIMIT || r < -rld_pkg::R_LIMIT) begin
            f = 0;
            break;
          end
          rprev = r;
          f = radial_fraction(rm * rm);
          r = rp + scaled_product(magnitude(f), f[63], rm, rprev[63], 44);
          it++;
          if (magnitude(r - rprev) <= tol) break;
        end
        one = 64'sd1 << 44;
        o.x = scale_by_divisor(x, one - f);
        o.y = scale_by_divisor(y, one - f);
      end
    end
    return o;
  endfunction

  function automatic logic signed [63:0] sign_ext48(input logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  always @(posedge clk) begin
    point_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rld_pkg::CFG_K0:  k0 <= sign_ext48(cfg_data);
          rld_pkg::CFG_K1:  k1 <= sign_ext48(cfg_data);
          rld_pkg::CFG_K2:  k2 <= sign_ext48(cfg_data);
          rld_pkg::CFG_EN:  coef_en <= cfg_data[0];
          rld_pkg::CFG_TOL: tol <= {33'd0, cfg_data[30:0]};
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_points = {expected_points, map_point(in_req_type, in_x_in, in_y_in)};
      if (out_valid && out_ready) begin
        got.x = out_x_out;
        got.y = out_y_out;
        if (expected_points.size() == 0) begin
          $error("unexpected result x_out %0d y_out %0d", got.x, got.y);
          nerr++;
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x) begin
            $error("x_out mismatch: expected %0d, actual %0d", want.x, got.x);
            nerr++;
          end
          if (got.y !== want.y) begin
            $error("y_out mismatch: expected %0d, actual %0d", want.y, got.y);
            nerr++;
          end
        end
      end
      pending = expected_points.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_req_type = 1'b0;
  logic signed [31:0]            in_x_in = '0;
  logic signed [31:0]            in_y_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [31:0]            out_x_out;
  logic signed [31:0]            out_y_out;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rld_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rld_pkg::COEF_W-1:0]    cfg_data = '0;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 0;
  bit hold_done = 0;
  int hold_left = 0;

  always #4 clk = ~clk;

  radial_lens_distortion_map dut (.*);

  rld_checker checker_i (.*);

  // receiver: random stalls, plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_start && !hold_done) begin
      hold_done = 1;
      hold_left = 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [rld_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rld_pkg::COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [47:0] c0, input logic [47:0] c1,
                            input logic [47:0] c2, input bit en, input logic [30:0] tl);
    drain();
    write_reg(rld_pkg::CFG_K0, c0);
    write_reg(rld_pkg::CFG_K1, c1);
    write_reg(rld_pkg::CFG_K2, c2);
    write_reg(rld_pkg::CFG_EN, {47'd0, en});
    write_reg(rld_pkg::CFG_TOL, {17'd0, tl});
  endtask

  task automatic send_point(input logic rt, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    bit lowered;
    lowered = 0;
    while ($urandom_range(99) < idle_pct) begin
      if (!lowered) in_valid <= 1'b0;
      lowered = 1;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_x_in     <= x;
    in_y_in     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic signed [31:0] x, y;
    repeat (n) begin
      x = $urandom();
      y = $urandom();
      case ($urandom_range(9))
        0: ;
        1: begin
          x = x >>> 17;
          y = y >>> 17;
        end
        2: begin
          x = x >>> 1;
          y = y >>> 24;
        end
        default: begin
          x = x >>> 3;
          y = y >>> 3;
        end
      endcase
      send_point(1'($urandom_range(1)), x, y);
    end
  endtask

  function automatic logic [47:0] rand_coef(input int shift);
    logic signed [63:0] v;
    v = {$urandom(), $urandom()};
    v = v >>> shift;
    return v[47:0];
  endfunction

  task automatic send_directed;
    for (int rt = 0; rt < 2; rt++) begin
      send_point(1'(rt), 0, 0);
      send_point(1'(rt), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(1'(rt), 32'sh8000_0000, 32'sh8000_0000);
      send_point(1'(rt), 32'sh7FFF_FFFF, 32'sh8000_0000);
      // both sides of the near-centre threshold
      send_point(1'(rt), 16777, 0);
      send_point(1'(rt), 0, -16778);
      send_point(1'(rt), 32'sd50331648, -32'sd83886080);
      send_point(1'(rt), -32'sd167772160, 32'sd16777216);
      send_point(1'(rt), 32'sd1, 32'sh8000_0000);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: identity mapping
    send_directed();

    load_coefs(48'd1759218604, -48'sd8796093022, 48'sd35184372, 1'b1, 31'd1678);
    send_directed();
    send_random(100);

    load_coefs(rand_coef(30), rand_coef(28), rand_coef(34), 1'b1, 31'd0);
    idle_pct = 61;
    send_random(80);

    load_coefs(-48'sd1759218604, 48'sd8796093022, -48'sd35184372, 1'b1, 31'd16777);
    idle_pct = 0;
    stall_pct = 61;
    hold_start = 1;
    send_random(80);

    load_coefs(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1,
               31'h7FFF_FFFF);
    idle_pct = 35;
    stall_pct = 35;
    send_directed();

    load_coefs(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000, 1'b1, 31'd0);
    send_directed();

    // divisor of exactly zero: wide tolerance lets the first update converge
    load_coefs(48'h1000_0000_0000, 48'd0, 48'd0, 1'b1, 31'h7FFF_FFFF);
    send_random(10);

    load_coefs(rand_coef(20), rand_coef(16), rand_coef(24), 1'b1, 31'($urandom()));
    idle_pct = 0;
    stall_pct = 0;
    send_random(100);

    load_coefs(rand_coef(0), rand_coef(0), rand_coef(0), 1'b0, 31'($urandom()));
    send_random(20);

    load_coefs(rand_coef(31), rand_coef(29), rand_coef(33), 1'b1, 31'($urandom_range(5000)));
    idle_pct = 35;
    stall_pct = 35;
    send_random(80);

    drain();
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== radial_lens_distortion_map.f =====
rtl/rld_pkg.sv
rtl/rld_mul.sv
rtl/rld_div.sv
rtl/rld_sqrt.sv
rtl/radial_lens_distortion_map.sv
verif/rld_checker.sv
verif/testbench.sv
